### sv/mwem_pkg.sv
// Package: types, codes and size helpers for the Microwire EEPROM master.
package mwem_pkg;

    localparam int MAX_ADDRESS_BITS = 11;
    localparam int DATA_BITS        = 16;

    localparam int ADDR_W_BITS = $clog2(MAX_ADDRESS_BITS + 1);
    localparam int DATA_W_BITS = $clog2(DATA_BITS + 1);
    localparam int FRAME_W     = MAX_ADDRESS_BITS + 3 + DATA_BITS;
    localparam int BITS_W      = $clog2(FRAME_W + 1);

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 3;

    localparam logic [CFG_INDEX_W-1:0] CFG_MODEL_SIZE        = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_WORD_ORGANIZATION = 2'd1;

    localparam logic OP_TICK    = 1'b0;
    localparam logic OP_COMMAND = 1'b1;

    localparam logic [2:0] CMD_READ      = 3'd0;
    localparam logic [2:0] CMD_WRITE     = 3'd1;
    localparam logic [2:0] CMD_ERASE     = 3'd2;
    localparam logic [2:0] CMD_WRITE_ALL = 3'd3;
    localparam logic [2:0] CMD_ERASE_ALL = 3'd4;
    localparam logic [2:0] CMD_ENABLE    = 3'd5;
    localparam logic [2:0] CMD_DISABLE   = 3'd6;

    localparam logic [1:0] OPC_EXTENDED = 2'd0;
    localparam logic [1:0] OPC_WRITE    = 2'd1;
    localparam logic [1:0] OPC_READ     = 2'd2;
    localparam logic [1:0] OPC_ERASE    = 2'd3;

    localparam logic [1:0] EXT_WRITE_ALL = 2'd1;
    localparam logic [1:0] EXT_ERASE_ALL = 2'd2;
    localparam logic [1:0] EXT_ENABLE    = 2'd3;

    localparam logic [2:0] MODEL_MAX = 3'd4;

    typedef struct packed {
        logic        op;
        logic [2:0]  command;
        logic [10:0] address;
        logic [15:0] write_data;
        logic        data_from_device;
    } item_t;

    typedef struct packed {
        logic        chip_select;
        logic        serial_clock;
        logic        data_to_device;
        logic        busy_res;
        logic        read_valid;
        logic [15:0] read_data;
        logic        command_refused;
    } result_t;

    function automatic logic [ADDR_W_BITS-1:0] addr_width(input logic [2:0] model_size,
                                                          input logic       word_org);
        logic [2:0]             m;
        logic [ADDR_W_BITS-1:0] a;
        m = (model_size > MODEL_MAX) ? MODEL_MAX : model_size;
        case (m)
            3'd0:    a = ADDR_W_BITS'(7);
            3'd1:    a = ADDR_W_BITS'(9);
            3'd2:    a = ADDR_W_BITS'(9);
            default: a = ADDR_W_BITS'(11);
        endcase
        if (word_org)
            a = a - ADDR_W_BITS'(1);
        if (a > ADDR_W_BITS'(MAX_ADDRESS_BITS))
            a = ADDR_W_BITS'(MAX_ADDRESS_BITS);
        return a;
    endfunction

    function automatic logic [DATA_W_BITS-1:0] data_width(input logic word_org);
        logic [DATA_W_BITS-1:0] d;
        d = word_org ? DATA_W_BITS'(16) : DATA_W_BITS'(8);
        if (d > DATA_W_BITS'(DATA_BITS))
            d = DATA_W_BITS'(DATA_BITS);
        return d;
    endfunction

endpackage

### sv/microwire_eeprom_master_unit.sv
// Top level: Microwire serial EEPROM master with registered result and skid stage.
// Each result is registered, held in the skid entry while an older result stalls.
// Throughput: one item per cycle unless stalled; the sequencer updates once per beat.
// A two-entry output stage (result register plus skid) keeps the item port open while
// one result waits; item_stall rises only when both entries are full.
// Reset: asynchronous, active low; lines low, sequencer idle, writes disabled, sizes zero.
module microwire_eeprom_master_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    output logic                                item_stall,
    input  mwem_pkg::item_t                     item,
    output logic                                result_valid,
    input  logic                                result_stall,
    output mwem_pkg::result_t                   result,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [mwem_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [mwem_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import mwem_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_SEND,
        PH_READ,
        PH_END,
        PH_WAIT
    } phase_t;

    phase_t                 phase_reg, phase_next;
    logic [2:0]             model_size_reg, model_size_next;
    logic                   word_org_reg, word_org_next;
    logic                   write_enabled_reg, write_enabled_next;
    logic [FRAME_W-1:0]     out_shift_reg, out_shift_next;
    logic [BITS_W-1:0]      bits_left_reg, bits_left_next;
    logic [1:0]             sub_phase_reg, sub_phase_next;
    logic [15:0]            in_shift_reg, in_shift_next;
    logic [2:0]             active_cmd_reg, active_cmd_next;
    logic [DATA_W_BITS-1:0] read_len_reg, read_len_next;
    logic                   cs_reg, cs_next;
    logic                   sk_reg, sk_next;
    logic                   di_reg, di_next;
    logic                   out_valid_reg, out_valid_next;
    result_t                out_reg, out_next;
    logic                   skid_valid_reg, skid_valid_next;
    result_t                skid_reg, skid_next;

    logic    accept;
    logic    take;
    result_t res;

    assign item_stall   = skid_valid_reg;
    assign accept       = item_valid && !item_stall;
    assign take         = out_valid_reg && !result_stall;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;
    assign cfg_ready    = 1'b1;

    always_comb
    begin
        logic [ADDR_W_BITS-1:0] aw;
        logic [DATA_W_BITS-1:0] dw;
        logic [FRAME_W-1:0]     amask;
        logic [FRAME_W-1:0]     dmask;
        logic [FRAME_W-1:0]     field;
        logic [FRAME_W-1:0]     frame;
        logic [BITS_W-1:0]      len;
        logic [BITS_W-1:0]      sh;
        logic [1:0]             opc;
        logic                   modifying;
        logic                   refused;
        logic                   rvalid;
        logic [15:0]            rdata;

        phase_next         = phase_reg;
        model_size_next    = model_size_reg;
        word_org_next      = word_org_reg;
        write_enabled_next = write_enabled_reg;
        out_shift_next     = out_shift_reg;
        bits_left_next     = bits_left_reg;
        sub_phase_next     = sub_phase_reg;
        in_shift_next      = in_shift_reg;
        active_cmd_next    = active_cmd_reg;
        read_len_next      = read_len_reg;
        cs_next            = cs_reg;
        sk_next            = sk_reg;
        di_next            = di_reg;

        aw        = addr_width(model_size_reg, word_org_reg);
        dw        = data_width(word_org_reg);
        amask     = (FRAME_W'(1) << aw) - FRAME_W'(1);
        dmask     = (FRAME_W'(1) << dw) - FRAME_W'(1);
        modifying = (item.command >= CMD_WRITE) && (item.command <= CMD_ERASE_ALL);
        refused   = 1'b0;
        rvalid    = 1'b0;
        rdata     = '0;
        sh        = bits_left_reg - BITS_W'(1);

        unique case (item.command)
            CMD_READ:
            begin
                opc   = OPC_READ;
                field = FRAME_W'(item.address) & amask;
            end
            CMD_WRITE:
            begin
                opc   = OPC_WRITE;
                field = FRAME_W'(item.address) & amask;
            end
            CMD_ERASE:
            begin
                opc   = OPC_ERASE;
                field = FRAME_W'(item.address) & amask;
            end
            CMD_WRITE_ALL:
            begin
                opc   = OPC_EXTENDED;
                field = FRAME_W'(EXT_WRITE_ALL) << (aw - ADDR_W_BITS'(2));
            end
            CMD_ERASE_ALL:
            begin
                opc   = OPC_EXTENDED;
                field = FRAME_W'(EXT_ERASE_ALL) << (aw - ADDR_W_BITS'(2));
            end
            CMD_ENABLE:
            begin
                opc   = OPC_EXTENDED;
                field = FRAME_W'(EXT_ENABLE) << (aw - ADDR_W_BITS'(2));
            end
            default:
            begin
                opc   = OPC_EXTENDED;
                field = '0;
            end
        endcase

        frame = (FRAME_W'(1) << (BITS_W'(aw) + BITS_W'(2)))
              | (FRAME_W'(opc) << aw) | field;
        len   = BITS_W'(aw) + BITS_W'(3);
        if (item.command == CMD_WRITE || item.command == CMD_WRITE_ALL)
        begin
            frame = (frame << dw) | (FRAME_W'(item.write_data) & dmask);
            len   = len + BITS_W'(dw);
        end

        if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_MODEL_SIZE)
                model_size_next = cfg_data;
            else if (cfg_index == CFG_WORD_ORGANIZATION)
                word_org_next = cfg_data[0];
        end

        if (accept)
        begin
            if (item.op == OP_COMMAND)
            begin
                if (phase_reg != PH_IDLE || item.command > CMD_DISABLE
                    || (modifying && !write_enabled_reg))
                begin
                    refused = 1'b1;
                end
                else
                begin
                    if (item.command == CMD_ENABLE)
                        write_enabled_next = 1'b1;
                    if (item.command == CMD_DISABLE)
                        write_enabled_next = 1'b0;
                    out_shift_next  = frame;
                    bits_left_next  = len;
                    sub_phase_next  = 2'd0;
                    in_shift_next   = '0;
                    read_len_next   = dw;
                    active_cmd_next = item.command;
                    phase_next      = PH_SEND;
                    cs_next         = 1'b1;
                    sk_next         = 1'b0;
                    di_next         = 1'b0;
                end
            end
            else
            begin
                unique case (phase_reg)
                    PH_SEND:
                    begin
                        if (sub_phase_reg == 2'd0)
                        begin
                            di_next        = out_shift_reg[sh];
                            sk_next        = 1'b0;
                            sub_phase_next = 2'd1;
                        end
                        else if (sub_phase_reg == 2'd1)
                        begin
                            sk_next        = 1'b1;
                            sub_phase_next = 2'd2;
                        end
                        else
                        begin
                            sk_next        = 1'b0;
                            sub_phase_next = 2'd0;
                            bits_left_next = bits_left_reg - BITS_W'(1);
                            if (bits_left_next == '0)
                            begin
                                if (active_cmd_reg == CMD_READ)
                                begin
                                    bits_left_next = BITS_W'(read_len_reg);
                                    phase_next     = PH_READ;
                                end
                                else
                                begin
                                    phase_next = PH_END;
                                end
                            end
                        end
                    end
                    PH_READ:
                    begin
                        if (sub_phase_reg == 2'd0)
                        begin
                            sk_next        = 1'b1;
                            sub_phase_next = 2'd1;
                        end
                        else
                        begin
                            in_shift_next  = {in_shift_reg[14:0], item.data_from_device};
                            sk_next        = 1'b0;
                            sub_phase_next = 2'd0;
                            bits_left_next = bits_left_reg - BITS_W'(1);
                            if (bits_left_next == '0)
                                phase_next = PH_END;
                        end
                    end
                    PH_END:
                    begin
                        cs_next = 1'b0;
                        sk_next = 1'b0;
                        if (active_cmd_reg >= CMD_WRITE && active_cmd_reg <= CMD_ERASE_ALL)
                        begin
                            phase_next = PH_WAIT;
                        end
                        else
                        begin
                            if (active_cmd_reg == CMD_READ)
                            begin
                                rvalid = 1'b1;
                                rdata  = in_shift_reg;
                            end
                            phase_next = PH_IDLE;
                        end
                    end
                    PH_WAIT:
                    begin
                        cs_next = 1'b1;
                        if (item.data_from_device)
                        begin
                            cs_next    = 1'b0;
                            phase_next = PH_IDLE;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end

        res.chip_select     = cs_next;
        res.serial_clock    = sk_next;
        res.data_to_device  = di_next;
        res.busy_res        = (phase_next != PH_IDLE);
        res.read_valid      = rvalid;
        res.read_data       = rdata;
        res.command_refused = refused;

        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;
        if (take && skid_valid_reg)
        begin
            out_next        = skid_reg;
            skid_valid_next = 1'b0;
        end
        else if (take || !out_valid_reg)
        begin
            out_valid_next = accept;
            out_next       = res;
        end
        else if (accept)
        begin
            skid_valid_next = 1'b1;
            skid_next       = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_IDLE;
            model_size_reg    <= '0;
            word_org_reg      <= 1'b0;
            write_enabled_reg <= 1'b0;
            out_shift_reg     <= '0;
            bits_left_reg     <= '0;
            sub_phase_reg     <= '0;
            in_shift_reg      <= '0;
            active_cmd_reg    <= '0;
            read_len_reg      <= '0;
            cs_reg            <= 1'b0;
            sk_reg            <= 1'b0;
            di_reg            <= 1'b0;
            out_valid_reg     <= 1'b0;
            out_reg           <= '0;
            skid_valid_reg    <= 1'b0;
            skid_reg          <= '0;
        end
        else
        begin
            phase_reg         <= phase_next;
            model_size_reg    <= model_size_next;
            word_org_reg      <= word_org_next;
            write_enabled_reg <= write_enabled_next;
            out_shift_reg     <= out_shift_next;
            bits_left_reg     <= bits_left_next;
            sub_phase_reg     <= sub_phase_next;
            in_shift_reg      <= in_shift_next;
            active_cmd_reg    <= active_cmd_next;
            read_len_reg      <= read_len_next;
            cs_reg            <= cs_next;
            sk_reg            <= sk_next;
            di_reg            <= di_next;
            out_valid_reg     <= out_valid_next;
            out_reg           <= out_next;
            skid_valid_reg    <= skid_valid_next;
            skid_reg          <= skid_next;
        end
    end

    skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held without a result beat in front");

    skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && out_valid_reg && result_stall) |=> skid_valid_reg)
        else $error("stalled result beat lost its follower");

    idle_lines_low: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_IDLE) |-> (!cs_reg && !sk_reg))
        else $error("serial lines active while sequencer idle");

    send_has_bits: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_SEND || phase_reg == PH_READ) |-> (bits_left_reg != '0))
        else $error("shift phase with no bits left");

    read_two_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_READ) |-> !sub_phase_reg[1])
        else $error("read bit beyond its second phase");

endmodule

### sim/microwire_eeprom_master_unit_tb.sv
// Self-checking testbench for the Microwire EEPROM master: directed table, then random sequences.
`timescale 1ns / 100ps

module microwire_eeprom_master_unit_tb;

    import mwem_pkg::*;

    typedef enum logic [2:0] {SEQ_IDLE, SEQ_SEND, SEQ_READ, SEQ_END, SEQ_WAIT} seq_phase_t;

    typedef struct {
        item_t   it;
        bit      typed;
        result_t want;
        bit      run;
        int      poll;
        int      fill;
    } vector_row_t;

    localparam logic [2:0] CMD_UNDEFINED   = 3'd7;
    localparam logic [1:0] CFG_FIRST_SPARE = 2'd2;
    localparam int         N_SETTINGS      = 6;
    localparam int         ITEMS_PER_SETTING = 24;
    localparam int         LONG_HOLD_CYCLES  = 80;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   item_valid = 1'b0;
    logic                   item_stall;
    item_t                  item_bus = '0;
    logic                   result_valid;
    logic                   result_stall = 1'b0;
    result_t                result_bus;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    // predictor state
    logic [2:0]  size_sel = '0;
    logic        word_org = 1'b0;
    logic        we_flag = 1'b0;
    seq_phase_t  seq_phase = SEQ_IDLE;
    logic [29:0] out_bits = '0;
    logic [4:0]  bits_left = '0;
    logic [1:0]  sub_step = '0;
    logic [15:0] in_bits = '0;
    logic [2:0]  active_cmd = '0;
    logic [4:0]  read_len = '0;
    logic        cs_level = 1'b0;
    logic        sk_level = 1'b0;
    logic        di_level = 1'b0;

    result_t     pending_lines[$];
    vector_row_t plan[$];

    int  n_errors = 0;
    int  n_items = 0;
    int  n_beats = 0;
    int  n_started = 0;
    int  n_refused = 0;
    int  n_reads = 0;
    bit  sender_quiet = 1'b0;
    bit  hold_request = 1'b0;

    logic [2:0] size_plan [N_SETTINGS] = '{3'd4, 3'd7, 3'd1, 3'd2, 3'd3, 3'd0};
    logic       org_plan  [N_SETTINGS] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1};

    microwire_eeprom_master_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item_bus),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result_bus),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic result_t predict_lines(input item_t it);
        result_t     r;
        int          a;
        int          d;
        int          len;
        logic [31:0] frame;
        logic [31:0] field;
        logic [1:0]  opc;
        logic        modifying;
        r = '0;
        if (it.op == OP_COMMAND)
        begin
            case (size_sel)
                3'd0:       a = 7;
                3'd1, 3'd2: a = 9;
                default:    a = 11;
            endcase
            if (word_org)
                a = a - 1;
            d = word_org ? 16 : 8;
            modifying = (it.command >= CMD_WRITE) && (it.command <= CMD_ERASE_ALL);
            if (seq_phase != SEQ_IDLE || it.command > CMD_DISABLE || (modifying && !we_flag))
            begin
                r.command_refused = 1'b1;
            end
            else
            begin
                opc = OPC_EXTENDED;
                field = '0;
                case (it.command)
                    CMD_READ:
                    begin
                        opc = OPC_READ;
                        field = 32'(it.address) & ((32'd1 << a) - 1);
                    end
                    CMD_WRITE:
                    begin
                        opc = OPC_WRITE;
                        field = 32'(it.address) & ((32'd1 << a) - 1);
                    end
                    CMD_ERASE:
                    begin
                        opc = OPC_ERASE;
                        field = 32'(it.address) & ((32'd1 << a) - 1);
                    end
                    CMD_WRITE_ALL: field = 32'(EXT_WRITE_ALL) << (a - 2);
                    CMD_ERASE_ALL: field = 32'(EXT_ERASE_ALL) << (a - 2);
                    CMD_ENABLE:    field = 32'(EXT_ENABLE) << (a - 2);
                    default:       field = '0;
                endcase
                frame = (32'd1 << (a + 2)) | (32'(opc) << a) | field;
                len = a + 3;
                if (it.command == CMD_WRITE || it.command == CMD_WRITE_ALL)
                begin
                    frame = (frame << d) | (32'(it.write_data) & ((32'd1 << d) - 1));
                    len = len + d;
                end
                if (it.command == CMD_ENABLE)
                    we_flag = 1'b1;
                if (it.command == CMD_DISABLE)
                    we_flag = 1'b0;
                out_bits = frame[29:0];
                bits_left = 5'(len);
                sub_step = 2'd0;
                in_bits = '0;
                read_len = 5'(d);
                active_cmd = it.command;
                seq_phase = SEQ_SEND;
                cs_level = 1'b1;
                sk_level = 1'b0;
                di_level = 1'b0;
            end
        end
        else
        begin
            case (seq_phase)
                SEQ_SEND:
                begin
                    if (sub_step == 2'd0)
                    begin
                        di_level = out_bits[bits_left - 1];
                        sk_level = 1'b0;
                        sub_step = 2'd1;
                    end
                    else if (sub_step == 2'd1)
                    begin
                        sk_level = 1'b1;
                        sub_step = 2'd2;
                    end
                    else
                    begin
                        sk_level = 1'b0;
                        sub_step = 2'd0;
                        bits_left = bits_left - 5'd1;
                        if (bits_left == 5'd0)
                        begin
                            if (active_cmd == CMD_READ)
                            begin
                                bits_left = read_len;
                                seq_phase = SEQ_READ;
                            end
                            else
                            begin
                                seq_phase = SEQ_END;
                            end
                        end
                    end
                end
                SEQ_READ:
                begin
                    if (sub_step == 2'd0)
                    begin
                        sk_level = 1'b1;
                        sub_step = 2'd1;
                    end
                    else
                    begin
                        in_bits = {in_bits[14:0], it.data_from_device};
                        sk_level = 1'b0;
                        sub_step = 2'd0;
                        bits_left = bits_left - 5'd1;
                        if (bits_left == 5'd0)
                            seq_phase = SEQ_END;
                    end
                end
                SEQ_END:
                begin
                    cs_level = 1'b0;
                    sk_level = 1'b0;
                    if (active_cmd >= CMD_WRITE && active_cmd <= CMD_ERASE_ALL)
                    begin
                        seq_phase = SEQ_WAIT;
                    end
                    else
                    begin
                        if (active_cmd == CMD_READ)
                        begin
                            r.read_valid = 1'b1;
                            r.read_data = in_bits;
                        end
                        seq_phase = SEQ_IDLE;
                    end
                end
                SEQ_WAIT:
                begin
                    cs_level = 1'b1;
                    if (it.data_from_device)
                    begin
                        cs_level = 1'b0;
                        seq_phase = SEQ_IDLE;
                    end
                end
                default:
                begin
                end
            endcase
        end
        r.chip_select = cs_level;
        r.serial_clock = sk_level;
        r.data_to_device = di_level;
        r.busy_res = (seq_phase != SEQ_IDLE);
        return r;
    endfunction

    task automatic flag_mismatch(input string field, input int got, input int want);
        n_errors++;
        $display("beat %0d: %s got %0h, want %0h", n_beats, field, got, want);
    endtask

    task automatic compare_beat(input result_t got);
        result_t want;
        if (pending_lines.size() == 0)
        begin
            flag_mismatch("beat with nothing pending", 1, 0);
        end
        else
        begin
            want = pending_lines.pop_front();
            if (got.chip_select !== want.chip_select)
                flag_mismatch("chip_select", got.chip_select, want.chip_select);
            if (got.serial_clock !== want.serial_clock)
                flag_mismatch("serial_clock", got.serial_clock, want.serial_clock);
            if (got.data_to_device !== want.data_to_device)
                flag_mismatch("data_to_device", got.data_to_device, want.data_to_device);
            if (got.busy_res !== want.busy_res)
                flag_mismatch("busy_res", got.busy_res, want.busy_res);
            if (got.read_valid !== want.read_valid)
                flag_mismatch("read_valid", got.read_valid, want.read_valid);
            if (got.read_data !== want.read_data)
                flag_mismatch("read_data", got.read_data, want.read_data);
            if (got.command_refused !== want.command_refused)
                flag_mismatch("command_refused", got.command_refused, want.command_refused);
            if (want.read_valid)
                n_reads++;
        end
        n_beats++;
    endtask

    task automatic drive_item(input item_t it, input bit typed, input result_t want);
        int      gap;
        result_t r;
        gap = sender_quiet ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_bus <= it;
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (item_stall !== 1'b0);
        r = predict_lines(it);
        pending_lines.push_back(typed ? want : r);
        n_items++;
        if (it.op == OP_COMMAND)
        begin
            if (r.command_refused)
                n_refused++;
            else
                n_started++;
        end
    endtask

    task automatic tick_to_idle(input int poll, input int fill);
        item_t   it;
        result_t none;
        int      waited;
        none = '0;
        waited = 0;
        while (seq_phase != SEQ_IDLE)
        begin
            it.op = OP_TICK;
            it.command = 3'($urandom);
            it.address = 11'($urandom);
            it.write_data = 16'($urandom);
            if (seq_phase == SEQ_WAIT)
            begin
                it.data_from_device = (poll < 0) ? ($urandom_range(0, 3) == 0) : (waited >= poll);
                waited++;
            end
            else if (fill < 0)
            begin
                it.data_from_device = 1'($urandom_range(0, 1));
            end
            else
            begin
                it.data_from_device = fill[0];
            end
            if (poll < 0 && $urandom_range(0, 29) == 0)
                it.op = OP_COMMAND;
            drive_item(it, 1'b0, none);
        end
    endtask

    task automatic run_command(input logic [2:0] cmd, input int poll);
        item_t   it;
        result_t none;
        none = '0;
        it.op = OP_COMMAND;
        it.command = cmd;
        it.address = 11'($urandom);
        it.write_data = 16'($urandom);
        it.data_from_device = 1'($urandom_range(0, 1));
        drive_item(it, 1'b0, none);
        tick_to_idle(poll, -1);
    endtask

    task automatic add_row(input logic op, input logic [2:0] cmd, input logic [10:0] addr,
                           input logic [15:0] wd, input bit typed, input result_t want,
                           input bit run, input int poll, input int fill);
        vector_row_t row;
        row.it.op = op;
        row.it.command = cmd;
        row.it.address = addr;
        row.it.write_data = wd;
        row.it.data_from_device = 1'b0;
        row.typed = typed;
        row.want = want;
        row.run = run;
        row.poll = poll;
        row.fill = fill;
        plan.push_back(row);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        if (idx == CFG_MODEL_SIZE)
            size_sel = val;
        else if (idx == CFG_WORD_ORGANIZATION)
            word_org = val[0];
    endtask

    task automatic reconfigure(input logic [2:0] ms, input logic wo);
        item_valid <= 1'b0;
        while (pending_lines.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        if ($urandom_range(0, 1))
            write_reg(CFG_FIRST_SPARE + 2'($urandom_range(0, 1)), 3'($urandom));
        write_reg(CFG_MODEL_SIZE, ms);
        write_reg(CFG_WORD_ORGANIZATION, {2'b00, wo});
        cfg_valid <= 1'b0;
    endtask

    // receiver: random stall per beat, quiet stretches, one long hold-off on request
    initial
    begin
        int hold;
        while (rst_n !== 1'b1)
            @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold = LONG_HOLD_CYCLES;
            end
            else if ((n_beats / 32) % 4 == 3)
            begin
                hold = 0;
            end
            else
            begin
                hold = $urandom_range(0, 11);
            end
            if (hold > 0)
            begin
                result_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            result_stall <= 1'b0;
            do
                @(posedge clk);
            while (result_valid !== 1'b1);
            compare_beat(result_bus);
        end
    end

    initial
    begin
        #1000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        result_t     zero_lines;
        result_t     refused_idle;
        result_t     enable_start;
        result_t     refused_busy;
        item_t       it;
        vector_row_t row;
        logic [2:0]  cmd;
        int          pick;
        int          budget;

        zero_lines = '0;
        refused_idle = '0;
        refused_idle.command_refused = 1'b1;
        enable_start = '0;
        enable_start.chip_select = 1'b1;
        enable_start.busy_res = 1'b1;
        refused_busy = enable_start;
        refused_busy.command_refused = 1'b1;

        add_row(OP_TICK,    CMD_READ,      11'h000, 16'h0000, 1, zero_lines,   0, 0, -1);
        add_row(OP_COMMAND, CMD_WRITE,     11'h7FF, 16'hFFFF, 1, refused_idle, 0, 0, -1);
        add_row(OP_COMMAND, CMD_ERASE,     11'h7FF, 16'h0000, 1, refused_idle, 0, 0, -1);
        add_row(OP_COMMAND, CMD_WRITE_ALL, 11'h000, 16'hFFFF, 1, refused_idle, 0, 0, -1);
        add_row(OP_COMMAND, CMD_ERASE_ALL, 11'h000, 16'h0000, 1, refused_idle, 0, 0, -1);
        add_row(OP_COMMAND, CMD_UNDEFINED, 11'h7FF, 16'hFFFF, 1, refused_idle, 0, 0, -1);
        add_row(OP_COMMAND, CMD_ENABLE,    11'h000, 16'h0000, 1, enable_start, 1, 0, -1);
        add_row(OP_COMMAND, CMD_READ,      11'h000, 16'h0000, 0, zero_lines,   1, 0, 0);
        add_row(OP_COMMAND, CMD_READ,      11'h7FF, 16'hFFFF, 0, zero_lines,   1, 0, 1);
        add_row(OP_COMMAND, CMD_WRITE,     11'h7FF, 16'hFFFF, 0, zero_lines,   1, 3, -1);
        add_row(OP_COMMAND, CMD_WRITE,     11'h000, 16'h0000, 0, zero_lines,   1, 0, -1);
        add_row(OP_COMMAND, CMD_ERASE,     11'h555, 16'h1234, 0, zero_lines,   1, 1, -1);
        add_row(OP_COMMAND, CMD_WRITE_ALL, 11'h2AA, 16'hAAAA, 0, zero_lines,   1, 2, -1);
        add_row(OP_COMMAND, CMD_ERASE_ALL, 11'h7FF, 16'h5555, 0, zero_lines,   1, 0, -1);
        add_row(OP_COMMAND, CMD_READ,      11'h2AA, 16'h0000, 0, zero_lines,   0, 0, -1);
        add_row(OP_COMMAND, CMD_READ,      11'h155, 16'h0000, 1, refused_busy, 1, 0, -1);
        add_row(OP_COMMAND, CMD_DISABLE,   11'h7FF, 16'hFFFF, 0, zero_lines,   1, 0, -1);
        add_row(OP_COMMAND, CMD_WRITE,     11'h123, 16'hBEEF, 0, zero_lines,   0, 0, -1);
        add_row(OP_TICK,    CMD_DISABLE,   11'h7FF, 16'hFFFF, 0, zero_lines,   0, 0, -1);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_reg(CFG_MODEL_SIZE, 3'd0);
        write_reg(CFG_WORD_ORGANIZATION, 3'd0);
        cfg_valid <= 1'b0;

        foreach (plan[i])
        begin
            row = plan[i];
            drive_item(row.it, row.typed, row.want);
            if (row.run)
                tick_to_idle(row.poll, row.fill);
        end

        for (int p = 0; p < N_SETTINGS; p++)
        begin
            reconfigure(size_plan[p], org_plan[p]);
            sender_quiet = (p % 3 == 1);
            if (p == 1)
                hold_request = 1'b1;
            budget = n_items + ITEMS_PER_SETTING;
            while (n_items < budget)
            begin
                if ($urandom_range(0, 4) == 0)
                begin
                    it.op = 1'($urandom_range(0, 1));
                    it.command = 3'($urandom);
                    it.address = 11'($urandom);
                    it.write_data = 16'($urandom);
                    it.data_from_device = 1'($urandom_range(0, 1));
                    drive_item(it, 1'b0, zero_lines);
                    tick_to_idle(-1, -1);
                end
                else
                begin
                    pick = $urandom_range(0, 99);
                    if (pick < 30)
                        cmd = CMD_READ;
                    else if (pick < 45)
                        cmd = CMD_WRITE;
                    else if (pick < 55)
                        cmd = CMD_ERASE;
                    else if (pick < 63)
                        cmd = CMD_WRITE_ALL;
                    else if (pick < 71)
                        cmd = CMD_ERASE_ALL;
                    else if (pick < 88)
                        cmd = CMD_ENABLE;
                    else
                        cmd = CMD_DISABLE;
                    if (cmd >= CMD_WRITE && cmd <= CMD_ERASE_ALL && !we_flag
                        && $urandom_range(0, 3) != 0)
                        run_command(CMD_ENABLE, -1);
                    run_command(cmd, -1);
                end
            end
        end

        item_valid <= 1'b0;
        while (pending_lines.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Covered %0d items in %0d beats over %0d size settings plus reset sizes.",
                 n_items, n_beats, N_SETTINGS);
        $display("Commands run: %0d, refused: %0d, read words checked: %0d.",
                 n_started, n_refused, n_reads);
        if (n_errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
